### rtl/pru_pkg.sv
// Shared types and constants for the pixel replicate upscaler.
// No dependencies; every rtl file but pru_line_store refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

   // line store geometry: two banks of one row each
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ADDR_W    = COL_W + 1;

   // fixed field widths
   localparam int PIXEL_W = 24;
   localparam int SCALE_W = 7;
   localparam int WIDTH_W = 11;
   localparam int KIND_W  = 2;
   localparam int PAD_W   = 2;
   localparam int CSR_W   = 11;

   localparam int SCALE_MAX = 100;

   // result queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // input operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAD   = 2'd2;

   // register indexes
   localparam logic CSR_SCALE = 1'b0;
   localparam logic CSR_WIDTH = 1'b1;

   // decoded word from front to back; pixel comes later from the line store
   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic              row_end;
      logic              dropped;
   } cmd_type;

   // line store access, at most one per accepted word
   typedef struct packed {
      logic               we;
      logic               re;
      logic [ADDR_W-1:0]  addr;
      logic [PIXEL_W-1:0] wdata;
   } ram_req_type;

   // finished result word held in the queue
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [PIXEL_W-1:0] pixel;
      logic               row_end;
      logic               dropped;
   } res_type;

endpackage

`default_nettype wire

### rtl/pixel_replicate_upscaler.sv
// Top level of the nearest-neighbour pixel upscaler.
// Instantiates pru_front, pru_line_store and pru_back; uses pru_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Integer nearest-neighbour upscaler for 24-bit pixel rows. Each req word is
// either a pixel write (tuser 0) or a tick (tuser 1), and every req word
// gives exactly one rsp word, in order. Writes fill a two-bank line store,
// one row per bank; a write into a bank still waiting to be drained is
// dropped and flagged. Ticks drain the full bank: each pixel repeats scale
// times across, the row is replayed scale times, each output row is followed
// by (width*scale) mod 4 zero pad bytes and its last word carries tlast.
// Throughput is one word per clock in both directions while rsp_tready is held
// high: the single-port line store is touched at most once per word (write or
// read), and all fill/drain counters update in that same cycle. The line
// store read data and the staged command are registered, then written into
// the queue, which raises rsp_tvalid. A four-word
// result queue absorbs rsp back-pressure; req_tready drops once it and the
// word in flight would fill it. Config writes are taken every cycle
// (csr_ready is tied high) and must only be made while the block is idle.
// scale is clamped to 1..100 and width_in to 1..1024 on write.

module pixel_replicate_upscaler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req: tdata = pixel_in[23:0]; tuser = operation
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [pru_pkg::PIXEL_W-1:0] req_tdata,
   input  wire logic                        req_tuser,
   // rsp: tdata = pixel_out[23:0]; tuser = kind[1:0], dropped[2]; tlast = row_end
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [pru_pkg::PIXEL_W-1:0]      rsp_tdata,
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast,
   // config: index 0 = scale (data[6:0]), index 1 = width_in (data[10:0])
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic                        csr_index,
   input  wire logic [pru_pkg::CSR_W-1:0]   csr_data
);

   pru_pkg::ram_req_type         ram_req;
   pru_pkg::cmd_type             cmd;
   logic [pru_pkg::PIXEL_W-1:0]  rd_pixel;
   logic                         queue_ready;

   pru_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_ready (queue_ready),
      .ram_req     (ram_req),
      .cmd         (cmd)
   );

   // two banks of MAX_WIDTH pixels, bank select is the top address bit
   pru_line_store #(
      .ADDR_W (pru_pkg::ADDR_W),
      .DATA_W (pru_pkg::PIXEL_W)
   ) u_line_store (
      .clock (clock),
      .we    (ram_req.we),
      .re    (ram_req.re),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (rd_pixel)
   );

   pru_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_pixel    (rd_pixel),
      .queue_ready (queue_ready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

### rtl/pru_line_store.sv
// Single-port line store with registered read data.
// Generic; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pru_line_store #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 24
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/pru_front.sv
// Front end: accepts words, holds config and all fill/drain counters,
// issues the line store access and a decoded command. Uses pru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pru_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic                         req_tuser,
   input  wire logic [pru_pkg::PIXEL_W-1:0]  req_tdata,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic                         csr_index,
   input  wire logic [pru_pkg::CSR_W-1:0]    csr_data,
   input  wire logic                         queue_ready,
   output pru_pkg::ram_req_type              ram_req,
   output pru_pkg::cmd_type                  cmd
);

   // config, held already clamped to its working range
   logic [pru_pkg::SCALE_W-1:0] scale_ff;
   logic [pru_pkg::WIDTH_W-1:0] width_ff;
   logic [pru_pkg::SCALE_W-1:0] scale_in;
   logic [pru_pkg::WIDTH_W-1:0] width_in;

   logic                        fill_bank_ff,    fill_bank_in;
   logic [pru_pkg::COL_W-1:0]   fill_column_ff,  fill_column_in;
   logic [1:0]                  bank_full_ff,    bank_full_in;
   logic                        drain_bank_ff,   drain_bank_in;
   logic [pru_pkg::COL_W-1:0]   drain_column_ff, drain_column_in;
   logic [pru_pkg::SCALE_W-1:0] across_ff,       across_in;
   logic [pru_pkg::SCALE_W-1:0] down_ff,         down_in;
   logic [pru_pkg::PAD_W-1:0]   pad_count_ff,    pad_count_in;
   logic                        in_padding_ff,   in_padding_in;

   logic                        accept;
   logic                        finish;
   logic [3:0]                  pad_prod;
   logic [pru_pkg::PAD_W-1:0]   pad_total;
   logic [pru_pkg::WIDTH_W-1:0] fill_next;
   logic [pru_pkg::WIDTH_W-1:0] col_next;
   logic [pru_pkg::SCALE_W:0]   across_next;
   logic [pru_pkg::SCALE_W:0]   down_next;
   logic [pru_pkg::PAD_W:0]     pad_next;

   assign req_tready = queue_ready;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & queue_ready;

   // 3*w*s == -(w*s) mod 4, so the pad length is just (w*s) mod 4
   assign pad_prod  = width_ff[1:0] * scale_ff[1:0];
   assign pad_total = pad_prod[pru_pkg::PAD_W-1:0];

   // clamp on write
   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pru_pkg::CSR_SCALE: begin
               if (csr_data[pru_pkg::SCALE_W-1:0] == '0) begin
                  scale_in = pru_pkg::SCALE_W'(1);
               end else if (csr_data[pru_pkg::SCALE_W-1:0] >
                            pru_pkg::SCALE_W'(pru_pkg::SCALE_MAX)) begin
                  scale_in = pru_pkg::SCALE_W'(pru_pkg::SCALE_MAX);
               end else begin
                  scale_in = csr_data[pru_pkg::SCALE_W-1:0];
               end
            end
            pru_pkg::CSR_WIDTH: begin
               if (csr_data == '0) begin
                  width_in = pru_pkg::WIDTH_W'(1);
               end else if (csr_data > pru_pkg::WIDTH_W'(pru_pkg::MAX_WIDTH)) begin
                  width_in = pru_pkg::WIDTH_W'(pru_pkg::MAX_WIDTH);
               end else begin
                  width_in = csr_data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      fill_bank_in    = fill_bank_ff;
      fill_column_in  = fill_column_ff;
      bank_full_in    = bank_full_ff;
      drain_bank_in   = drain_bank_ff;
      drain_column_in = drain_column_ff;
      across_in       = across_ff;
      down_in         = down_ff;
      pad_count_in    = pad_count_ff;
      in_padding_in   = in_padding_ff;
      finish          = 1'b0;

      fill_next   = {1'b0, fill_column_ff} + pru_pkg::WIDTH_W'(1);
      col_next    = {1'b0, drain_column_ff} + pru_pkg::WIDTH_W'(1);
      across_next = {1'b0, across_ff} + (pru_pkg::SCALE_W + 1)'(1);
      down_next   = {1'b0, down_ff} + (pru_pkg::SCALE_W + 1)'(1);
      pad_next    = {1'b0, pad_count_ff} + (pru_pkg::PAD_W + 1)'(1);

      ram_req.we    = 1'b0;
      ram_req.re    = 1'b0;
      ram_req.addr  = {fill_bank_ff, fill_column_ff};
      ram_req.wdata = req_tdata;

      cmd.valid   = accept;
      cmd.kind    = pru_pkg::KIND_NONE;
      cmd.row_end = 1'b0;
      cmd.dropped = 1'b0;

      if (accept) begin
         priority if (req_tuser == pru_pkg::OP_WRITE) begin
            if (bank_full_ff[fill_bank_ff]) begin
               cmd.dropped = 1'b1;
            end else begin
               ram_req.we = 1'b1;
               if (fill_next >= width_ff) begin
                  fill_column_in               = '0;
                  bank_full_in[fill_bank_ff]   = 1'b1;
                  fill_bank_in                 = ~fill_bank_ff;
               end else begin
                  fill_column_in = fill_next[pru_pkg::COL_W-1:0];
               end
            end
         end else if (in_padding_ff) begin
            cmd.kind = pru_pkg::KIND_PAD;
            if (pad_next >= {1'b0, pad_total}) begin
               pad_count_in  = '0;
               in_padding_in = 1'b0;
               cmd.row_end   = 1'b1;
               finish        = 1'b1;
            end else begin
               pad_count_in = pad_next[pru_pkg::PAD_W-1:0];
            end
         end else if (bank_full_ff[drain_bank_ff]) begin
            cmd.kind     = pru_pkg::KIND_PIXEL;
            ram_req.re   = 1'b1;
            ram_req.addr = {drain_bank_ff, drain_column_ff};
            if (across_next >= {1'b0, scale_ff}) begin
               across_in = '0;
               if (col_next >= width_ff) begin
                  drain_column_in = '0;
                  if (pad_total != '0) begin
                     in_padding_in = 1'b1;
                     pad_count_in  = '0;
                  end else begin
                     cmd.row_end = 1'b1;
                     finish      = 1'b1;
                  end
               end else begin
                  drain_column_in = col_next[pru_pkg::COL_W-1:0];
               end
            end else begin
               across_in = across_next[pru_pkg::SCALE_W-1:0];
            end
         end else begin
            // idle tick: nothing to give
            cmd.kind = pru_pkg::KIND_NONE;
         end
      end

      // end of an output row: count replays, release the bank after the last
      if (finish) begin
         if (down_next >= {1'b0, scale_ff}) begin
            down_in                     = '0;
            bank_full_in[drain_bank_ff] = 1'b0;
            drain_bank_in               = ~drain_bank_ff;
         end else begin
            down_in = down_next[pru_pkg::SCALE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= pru_pkg::SCALE_W'(1);
         width_ff        <= pru_pkg::WIDTH_W'(1);
         fill_bank_ff    <= 1'b0;
         fill_column_ff  <= '0;
         bank_full_ff    <= '0;
         drain_bank_ff   <= 1'b0;
         drain_column_ff <= '0;
         across_ff       <= '0;
         down_ff         <= '0;
         pad_count_ff    <= '0;
         in_padding_ff   <= 1'b0;
      end else begin
         scale_ff        <= scale_in;
         width_ff        <= width_in;
         fill_bank_ff    <= fill_bank_in;
         fill_column_ff  <= fill_column_in;
         bank_full_ff    <= bank_full_in;
         drain_bank_ff   <= drain_bank_in;
         drain_column_ff <= drain_column_in;
         across_ff       <= across_in;
         down_ff         <= down_in;
         pad_count_ff    <= pad_count_in;
         in_padding_ff   <= in_padding_in;
      end
   end

`ifndef NO_ASSERTIONS
   // reads only come from a filled bank, never while padding
   a_read_full_bank: assert property (@(posedge clock) disable iff (reset)
      ram_req.re |-> (bank_full_ff[drain_bank_ff] && !in_padding_ff))
      else $error("line store read from a bank that is not full");

   // a full bank is never overwritten
   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      ram_req.we |-> !bank_full_ff[fill_bank_ff])
      else $error("line store write into a full bank");

   // mid-row the drained bank stays full
   a_mid_row_full: assert property (@(posedge clock) disable iff (reset)
      (drain_column_ff != '0 || across_ff != '0) |-> bank_full_ff[drain_bank_ff])
      else $error("drain bank released in the middle of a row");

   // a bank is released only on the word that ends a row
   a_release_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (bank_full_ff[drain_bank_ff] && !bank_full_in[drain_bank_ff]) |-> cmd.row_end)
      else $error("drain bank released without a row end");
`endif

endmodule

`default_nettype wire

### rtl/pru_back.sv
// Back end: aligns decoded commands with line store data and queues the
// finished result words for the rsp channel. Uses pru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pru_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pru_pkg::cmd_type            cmd,
   input  wire logic [pru_pkg::PIXEL_W-1:0] rd_pixel,
   output logic                             queue_ready,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [pru_pkg::PIXEL_W-1:0]      rsp_tdata,
   output logic [2:0]                       rsp_tuser,
   output logic                             rsp_tlast
);

   pru_pkg::cmd_type            stage_ff;
   pru_pkg::res_type            entry;
   pru_pkg::res_type            head;
   pru_pkg::res_type            queue_ff [pru_pkg::QUEUE_DEPTH];
   logic [pru_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pru_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pru_pkg::QCNT_W-1:0]  count_ff,  count_in;
   logic                        push;
   logic                        pop;

   // read data lands in the cycle after the command, together with stage_ff
   always_comb begin
      entry.kind    = stage_ff.kind;
      entry.pixel   = (stage_ff.kind == pru_pkg::KIND_PIXEL) ? rd_pixel : '0;
      entry.row_end = stage_ff.row_end;
      entry.dropped = stage_ff.dropped;
   end

   assign push = stage_ff.valid;
   assign pop  = rsp_tvalid & rsp_tready;

   // room for the staged word as well as the one about to be accepted
   assign queue_ready = (count_ff + pru_pkg::QCNT_W'(stage_ff.valid)) <
                        pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pru_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pru_pkg::QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + pru_pkg::QCNT_W'(1);
         2'b01:   count_in = count_ff - pru_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         stage_ff.valid <= cmd.valid;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
      stage_ff.kind    <= cmd.kind;
      stage_ff.row_end <= cmd.row_end;
      stage_ff.dropped <= cmd.dropped;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = head.pixel;
   assign rsp_tuser  = {head.dropped, head.kind};
   assign rsp_tlast  = head.row_end;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH) || pop))
      else $error("result queue overflow");

   // an accepted word is pushed into the queue on the next edge
   a_cmd_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |=> push)
      else $error("accepted word lost before the queue");
`endif

endmodule

`default_nettype wire

### tb/tb_pixel_replicate_upscaler.sv
// Self-checking testbench for pixel_replicate_upscaler: a directed plan and then
// random traffic, every rsp word compared with a behavioural upscaler model.
// Depends on rtl/pru_pkg.sv and rtl/pixel_replicate_upscaler.sv.
`timescale 1ns / 1ps

module tb_pixel_replicate_upscaler;

   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;     // pipe settle margin before a csr write
   localparam int DRAIN_CYCLES  = 10;
   localparam int LONG_HOLD     = 300;   // rsp back-pressure long enough to fill the queue
   localparam int HOLD_AT       = 150;   // rsp word after which the long hold-off starts
   localparam int QUIET_LIMIT   = 5000;  // cycles with no handshake at all
   localparam int BURST_ITEMS   = 200;   // back-to-back run that the long hold-off lands in
   localparam int RANDOM_ITEMS  = 680;

   // one row of the directed plan: an item, or a register write
   typedef struct packed {
      logic                        is_cfg;
      logic                        sel;     // operation, or register index on config rows
      logic [pru_pkg::PIXEL_W-1:0] value;
      logic                        typed;   // result written out by hand below
      pru_pkg::res_type            want;
   } plan_row_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [pru_pkg::PIXEL_W-1:0] req_tdata  = '0;
   logic                        req_tuser  = pru_pkg::OP_WRITE;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [pru_pkg::PIXEL_W-1:0] rsp_tdata;
   logic [2:0]                  rsp_tuser;
   logic                        rsp_tlast;
   logic                        csr_valid  = 1'b0;
   logic                        csr_ready;
   logic                        csr_index  = pru_pkg::CSR_SCALE;
   logic [pru_pkg::CSR_W-1:0]   csr_data   = '0;

   always #(HALF_PERIOD) clock = ~clock;

   pixel_replicate_upscaler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_in[23:0]
      .req_tuser  (req_tuser),   // operation
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // pixel_out[23:0]
      .rsp_tuser  (rsp_tuser),   // kind[1:0], dropped[2]
      .rsp_tlast  (rsp_tlast),   // row_end
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // Upscaler model: own copy of the line store, fill/drain counters and
   // registers. Stepped once per accepted req word, in acceptance order.
   // ---------------------------------------------------------------------
   logic [pru_pkg::PIXEL_W-1:0] line_copy    [0:2*pru_pkg::MAX_WIDTH-1];
   bit                          line_written [0:2*pru_pkg::MAX_WIDTH-1];  // guards width growth
   logic [pru_pkg::SCALE_W-1:0] scale_reg  = 7'd1;
   logic [pru_pkg::WIDTH_W-1:0] width_reg  = 11'd1;
   bit   [1:0]                  bank_full  = 2'b00;
   int                          fill_bank  = 0;
   int                          fill_col   = 0;
   int                          drain_bank = 0;
   int                          drain_col  = 0;
   int                          across_cnt = 0;
   int                          down_cnt   = 0;
   int                          pad_cnt    = 0;
   bit                          in_pad     = 1'b0;

   pru_pkg::res_type pending_results [$];   // predicted rsp words, oldest first
   plan_row_type     directed_plan   [$];
   int               mismatch_count = 0;

   function automatic int clamp_width(int w);
      if (w == 0) return 1;
      if (w > pru_pkg::MAX_WIDTH) return pru_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int eff_width();
      return clamp_width(int'(width_reg));
   endfunction

   function automatic int eff_scale();
      if (scale_reg == 0) return 1;
      if (scale_reg > pru_pkg::SCALE_MAX) return pru_pkg::SCALE_MAX;
      return int'(scale_reg);
   endfunction

   // zero bytes that round a 3-byte-per-pixel output row up to a multiple of 4 bytes
   function automatic int pad_len();
      int bytes;
      bytes = 3 * eff_width() * eff_scale();
      return (4 - (bytes % 4)) % 4;
   endfunction

   // end of one output row; last replay frees the bank and swaps
   function automatic void close_out_row();
      down_cnt++;
      if (down_cnt >= eff_scale()) begin
         down_cnt              = 0;
         bank_full[drain_bank] = 1'b0;
         drain_bank            = drain_bank ^ 1;
      end
   endfunction

   function automatic pru_pkg::res_type upscale_predict(logic op,
                                                        logic [pru_pkg::PIXEL_W-1:0] pixel);
      pru_pkg::res_type r;
      int               col;
      r = '0;
      if (op == pru_pkg::OP_WRITE) begin
         if (bank_full[fill_bank]) begin
            r.dropped = 1'b1;
         end else begin
            col = fill_col % pru_pkg::MAX_WIDTH;
            line_copy[fill_bank*pru_pkg::MAX_WIDTH + col]    = pixel;
            line_written[fill_bank*pru_pkg::MAX_WIDTH + col] = 1'b1;
            fill_col = col + 1;
            if (fill_col >= eff_width()) begin
               fill_col             = 0;
               bank_full[fill_bank] = 1'b1;
               fill_bank            = fill_bank ^ 1;
            end
         end
      end else if (in_pad) begin
         r.kind = pru_pkg::KIND_PAD;
         pad_cnt++;
         // >= so that a smaller pad count set mid-padding ends at once
         if (pad_cnt >= pad_len()) begin
            pad_cnt   = 0;
            in_pad    = 1'b0;
            r.row_end = 1'b1;
            close_out_row();
         end
      end else if (bank_full[drain_bank]) begin
         col     = drain_col % pru_pkg::MAX_WIDTH;
         r.kind  = pru_pkg::KIND_PIXEL;
         r.pixel = line_copy[drain_bank*pru_pkg::MAX_WIDTH + col];
         across_cnt++;
         drain_col = col;
         if (across_cnt >= eff_scale()) begin
            across_cnt = 0;
            drain_col  = col + 1;
            if (drain_col >= eff_width()) begin
               drain_col = 0;
               if (pad_len() > 0) begin
                  in_pad  = 1'b1;
                  pad_cnt = 0;
               end else begin
                  r.row_end = 1'b1;
                  close_out_row();
               end
            end
         end
      end
      return r;
   endfunction

   // widest row that every full bank can still be drained at without
   // touching a store entry that was never written
   function automatic int width_cap();
      int cap;
      cap = pru_pkg::MAX_WIDTH;
      for (int b = 0; b < 2; b++)
         if (bank_full[b])
            for (int i = 0; i < cap; i++)
               if (!line_written[b*pru_pkg::MAX_WIDTH + i]) begin
                  cap = i;
                  break;
               end
      return cap;
   endfunction

   function automatic pru_pkg::res_type mk_res(logic [pru_pkg::KIND_W-1:0] k,
                                               logic [pru_pkg::PIXEL_W-1:0] p,
                                               logic rend, logic drop);
      pru_pkg::res_type r;
      r.kind    = k;
      r.pixel   = p;
      r.row_end = rend;
      r.dropped = drop;
      return r;
   endfunction

   function automatic void plan_word(logic op, logic [pru_pkg::PIXEL_W-1:0] pixel, bit typed,
                                     pru_pkg::res_type want);
      plan_row_type row;
      row.is_cfg = 1'b0;
      row.sel    = op;
      row.value  = pixel;
      row.typed  = typed;
      row.want   = want;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_reg(logic index, logic [pru_pkg::CSR_W-1:0] value);
      plan_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.sel    = index;
      row.value  = pru_pkg::PIXEL_W'(value);
      directed_plan.push_back(row);
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [pru_pkg::CSR_W-1:0] pick_scale();
      logic [pru_pkg::CSR_W-1:0] w;
      int                        r;
      w = pru_pkg::CSR_W'($urandom);   // bits above the scale field are don't-care
      r = $urandom_range(0, 19);
      case (r)
         0:       w[pru_pkg::SCALE_W-1:0] = 7'd0;
         1:       w[pru_pkg::SCALE_W-1:0] = 7'd100;
         2:       w[pru_pkg::SCALE_W-1:0] = 7'd127;
         3:       w[pru_pkg::SCALE_W-1:0] = pru_pkg::SCALE_W'($urandom_range(0, 127));
         default: w[pru_pkg::SCALE_W-1:0] = pru_pkg::SCALE_W'($urandom_range(1, 4));
      endcase
      return w;
   endfunction

   function automatic logic [pru_pkg::CSR_W-1:0] pick_width();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return 11'd0;
         1:       return 11'd1024;
         2:       return 11'd2047;
         3:       return pru_pkg::CSR_W'($urandom_range(0, 2047));
         4, 5:    return pru_pkg::CSR_W'($urandom_range(9, 48));
         default: return pru_pkg::CSR_W'($urandom_range(1, 8));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // req side. valid is only lowered ahead of a gap, a register write or the final
   // drain, so a back-to-back word never sees two assignments to req_tvalid in one time step.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic op, input logic [pru_pkg::PIXEL_W-1:0] pixel,
                            input int gap, input bit typed, input pru_pkg::res_type want);
      pru_pkg::res_type r;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pixel;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      r = upscale_predict(op, pixel);
      pending_results.push_back(typed ? want : r);
   endtask

   // Register writes only with the block idle: every result back, then the
   // pipe given time to settle. Width is held to what the full banks allow.
   task automatic program_regs(input bit set_scale, input logic [pru_pkg::CSR_W-1:0] scale_word,
                               input bit set_width, input logic [pru_pkg::CSR_W-1:0] width_word);
      int cap;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (set_scale) begin
         csr_valid <= 1'b1;
         csr_index <= pru_pkg::CSR_SCALE;
         csr_data  <= scale_word;
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         scale_reg = scale_word[pru_pkg::SCALE_W-1:0];
      end
      if (set_width) begin
         cap = width_cap();
         if (clamp_width(int'(width_word)) > cap) width_word = pru_pkg::CSR_W'(cap);
         csr_valid <= 1'b1;
         csr_index <= pru_pkg::CSR_WIDTH;
         csr_data  <= width_word;
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         width_reg = width_word[pru_pkg::WIDTH_W-1:0];
      end
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random stalls, quiet stretches with ready held high, and one
   // long hold-off so the result queue fills and req stalls.
   // ---------------------------------------------------------------------
   int taken      = 0;
   int hold_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) taken <= taken + 1;
         if (rsp_tvalid && rsp_tready && (taken + 1) == HOLD_AT) begin
            hold_left  <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            // every 512 words, 128 of them go through with no stalls
            if (taken % 512 >= 128 && $urandom_range(0, 99) < 25) stall_left <= gap_len();
         end
      end
   end

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_result
      pru_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("rsp word with nothing outstanding: kind %0d, pixel 0x%0h",
                   rsp_tuser[1:0], rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind",      32'(want.kind),    32'(rsp_tuser[1:0]));
            compare_field("pixel_out", 32'(want.pixel),   32'(rsp_tdata));
            compare_field("row_end",   32'(want.row_end), 32'(rsp_tlast));
            compare_field("dropped",   32'(want.dropped), 32'(rsp_tuser[2]));
         end
      end
   end

   // watchdog: any handshake restarts the count
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [pru_pkg::PIXEL_W-1:0] pix;
      logic                        op;
      int                          tick_pct;
      int                          phase_len;
      bit                          steady;
      int                          sent;

      // Directed plan. Hand-typed results only where obvious; the rest go
      // through the model. Reset state is scale 1, width 1.
      // tick with nothing stored: empty result, pixel bits ignored
      plan_word(pru_pkg::OP_TICK,  24'hFFFFFF, 1'b1,
                mk_res(pru_pkg::KIND_NONE, '0, 1'b0, 1'b0));
      plan_word(pru_pkg::OP_WRITE, 24'h000000, 1'b1,
                mk_res(pru_pkg::KIND_NONE, '0, 1'b0, 1'b0));
      plan_word(pru_pkg::OP_WRITE, 24'hFFFFFF, 1'b1,
                mk_res(pru_pkg::KIND_NONE, '0, 1'b0, 1'b0));
      // both banks now full: write is thrown away and flagged
      plan_word(pru_pkg::OP_WRITE, 24'hA5A5A5, 1'b1,
                mk_res(pru_pkg::KIND_NONE, '0, 1'b0, 1'b1));
      // width 1 x scale 1 gives 3 bytes, so one pad byte closes the row
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b1,
                mk_res(pru_pkg::KIND_PIXEL, 24'h000000, 1'b0, 1'b0));
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b1,
                mk_res(pru_pkg::KIND_PAD, '0, 1'b1, 1'b0));
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b1,
                mk_res(pru_pkg::KIND_PIXEL, 24'hFFFFFF, 1'b0, 1'b0));
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b1,
                mk_res(pru_pkg::KIND_PAD, '0, 1'b1, 1'b0));
      // scale 0 behaves as 1 (upper data bits ignored); width 4 needs no padding
      plan_reg(pru_pkg::CSR_SCALE, 11'h780);
      plan_reg(pru_pkg::CSR_WIDTH, 11'd4);
      plan_word(pru_pkg::OP_WRITE, 24'h123456, 1'b0, '0);
      plan_word(pru_pkg::OP_WRITE, 24'h800000, 1'b0, '0);
      plan_word(pru_pkg::OP_WRITE, 24'h000001, 1'b0, '0);
      plan_word(pru_pkg::OP_WRITE, 24'h7FFFFF, 1'b0, '0);
      repeat (4) plan_word(pru_pkg::OP_TICK, 24'h0, 1'b0, '0);
      // scale above range clamps to 100, width 0 behaves as 1
      plan_reg(pru_pkg::CSR_SCALE, 11'h7FF);
      plan_reg(pru_pkg::CSR_WIDTH, 11'd0);
      plan_word(pru_pkg::OP_WRITE, 24'h5A5A5A, 1'b0, '0);
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b0, '0);
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b0, '0);
      // scale cut mid-row: repeat count already past the new limit
      plan_reg(pru_pkg::CSR_SCALE, 11'd2);
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b0, '0);
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b0, '0);
      // scale cut mid-padding: pad count ends at once
      plan_reg(pru_pkg::CSR_SCALE, 11'd1);
      plan_word(pru_pkg::OP_TICK,  24'h0,      1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_cfg)
            program_regs(directed_plan[i].sel == pru_pkg::CSR_SCALE,
                         directed_plan[i].value[pru_pkg::CSR_W-1:0],
                         directed_plan[i].sel == pru_pkg::CSR_WIDTH,
                         directed_plan[i].value[pru_pkg::CSR_W-1:0]);
         else
            send_word(directed_plan[i].sel, directed_plan[i].value, gap_len(),
                      directed_plan[i].typed, directed_plan[i].want);
      end

      // Back-to-back run: the long rsp hold-off starts in here, so the queue
      // fills and req stalls while words keep being offered.
      program_regs(1'b1, 11'd2, 1'b1, 11'd3);
      repeat (BURST_ITEMS) begin
         op  = ($urandom_range(0, 99) < 60) ? pru_pkg::OP_TICK : pru_pkg::OP_WRITE;
         pix = pru_pkg::PIXEL_W'($urandom);
         send_word(op, pix, 0, 1'b0, '0);
      end

      // Random phases: new registers in most phases, a tick/write mix that
      // suits either filling or draining, some phases with no req gaps.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 0) program_regs(1'b1, pick_scale(), 1'b1, pick_width());
         case ($urandom_range(0, 2))
            0:       tick_pct = 30;
            1:       tick_pct = 65;
            default: tick_pct = 88;
         endcase
         steady    = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            op  = ($urandom_range(0, 99) < tick_pct) ? pru_pkg::OP_TICK : pru_pkg::OP_WRITE;
            pix = pru_pkg::PIXEL_W'($urandom);
            send_word(op, pix, steady ? 0 : gap_len(), 1'b0, '0);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
